FILE: hdl/cpr_pkg.sv
`default_nettype none
package cpr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int NUM_BLOCKS = 256;
  localparam int MAX_PROCS  = 16;
  localparam int MAX_PAGES  = 64;

  localparam int FRAME_W = 6;
  localparam int FCNT_W  = 7;
  localparam int BLOCK_W = 8;
  localparam int BCNT_W  = 9;
  localparam int SLOT_W  = 4;
  localparam int PAGE_W  = 6;
  localparam int PCNT_W  = 7;
  localparam int KEY_W   = SLOT_W + PAGE_W;
  localparam int SCAN_W  = 9;

  // command codes
  localparam logic [1:0] CMD_EXTEND  = 2'd0;
  localparam logic [1:0] CMD_FAULT   = 2'd1;
  localparam logic [1:0] CMD_DESTROY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK   = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC  = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  // action codes
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_GRANT_RW = 2'd1;
  localparam logic [1:0] ACT_MAP_ZERO = 2'd2;
  localparam logic [1:0] ACT_MAP_DISK = 2'd3;

  // configuration register indexes
  localparam logic REG_FRAMES = 1'b0;
  localparam logic REG_BLOCKS = 1'b1;

  // page table entry
  typedef struct packed {
    logic               resident;
    logic               dirty;
    logic [FRAME_W-1:0] frame;
    logic [BLOCK_W-1:0] block;
  } pte_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_SCAN_INC,
    OP_NO_BLOCK,
    OP_EXT_FULL,
    OP_EXT_COMMIT,
    OP_BAD_PAGE,
    OP_PTE_RD,
    OP_GRANT,
    OP_SAVE_BLK,
    OP_TAKE_FREE,
    OP_HAND_NORM,
    OP_CLOCK_STEP,
    OP_OWNER_RD,
    OP_VIC_RD,
    OP_EVICT,
    OP_MAP,
    OP_DST_RD,
    OP_DST_FREE,
    OP_DST_DONE,
    OP_LOAD
  } op_t;

  // conditions reported back to the controller
  typedef struct packed {
    logic blk_end;
    logic blk_hit;
    logic tbl_full;
    logic page_bad;
    logic pte_res;
    logic frm_end;
    logic frm_hit;
    logic hand_clear;
    logic dst_more;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/cpr_ctrl.sv
`default_nettype none
module cpr_ctrl import cpr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] command,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t st,
  output op_t             op
);

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_EXT_SCAN  = 14'b00000000000010,
    S_FLT_READ  = 14'b00000000000100,
    S_FLT_CHECK = 14'b00000000001000,
    S_FLT_FREE  = 14'b00000000010000,
    S_FLT_CLOCK = 14'b00000000100000,
    S_FLT_OWNER = 14'b00000001000000,
    S_FLT_VREAD = 14'b00000010000000,
    S_FLT_EVICT = 14'b00000100000000,
    S_FLT_MAP   = 14'b00001000000000,
    S_DST_READ  = 14'b00010000000000,
    S_DST_FREE  = 14'b00100000000000,
    S_FINISH    = 14'b01000000000000,
    S_SPARE     = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  // next state and operation
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_START;
          case (command)
            CMD_EXTEND:  state_next = S_EXT_SCAN;
            CMD_FAULT:   state_next = S_FLT_READ;
            CMD_DESTROY: state_next = S_DST_READ;
            default:     state_next = S_FINISH;
          endcase
        end
      end
      S_EXT_SCAN: begin
        if (st.blk_end) begin
          op = OP_NO_BLOCK;
          state_next = S_FINISH;
        end else if (st.blk_hit) begin
          op = st.tbl_full ? OP_EXT_FULL : OP_EXT_COMMIT;
          state_next = S_FINISH;
        end else begin
          op = OP_SCAN_INC;
        end
      end
      S_FLT_READ: begin
        if (st.page_bad) begin
          op = OP_BAD_PAGE;
          state_next = S_FINISH;
        end else begin
          op = OP_PTE_RD;
          state_next = S_FLT_CHECK;
        end
      end
      S_FLT_CHECK: begin
        if (st.pte_res) begin
          op = OP_GRANT;
          state_next = S_FINISH;
        end else begin
          op = OP_SAVE_BLK;
          state_next = S_FLT_FREE;
        end
      end
      S_FLT_FREE: begin
        if (st.frm_hit) begin
          op = OP_TAKE_FREE;
          state_next = S_FLT_MAP;
        end else if (st.frm_end) begin
          op = OP_HAND_NORM;
          state_next = S_FLT_CLOCK;
        end else begin
          op = OP_SCAN_INC;
        end
      end
      S_FLT_CLOCK: begin
        op = OP_CLOCK_STEP;
        if (st.hand_clear) state_next = S_FLT_OWNER;
      end
      S_FLT_OWNER: begin
        op = OP_OWNER_RD;
        state_next = S_FLT_VREAD;
      end
      S_FLT_VREAD: begin
        op = OP_VIC_RD;
        state_next = S_FLT_EVICT;
      end
      S_FLT_EVICT: begin
        op = OP_EVICT;
        state_next = S_FLT_MAP;
      end
      S_FLT_MAP: begin
        op = OP_MAP;
        state_next = S_FINISH;
      end
      S_DST_READ: begin
        if (st.dst_more) begin
          op = OP_DST_RD;
          state_next = S_DST_FREE;
        end else begin
          op = OP_DST_DONE;
          state_next = S_FINISH;
        end
      end
      S_DST_FREE: begin
        op = OP_DST_FREE;
        state_next = S_DST_READ;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          op = OP_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result beat held until taken
  assign out_valid_next = (op == OP_LOAD) || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cpr_datapath.sv
`default_nettype none
module cpr_datapath import cpr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire op_t                op,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [BCNT_W-1:0]  cfg_data,
  input  wire logic [SLOT_W-1:0]  process_slot,
  input  wire logic [PAGE_W-1:0]  page_index,
  output dp_status_t              st,
  output logic [1:0]              status,
  output logic [1:0]              action,
  output logic [FRAME_W-1:0]      frame,
  output logic [PAGE_W-1:0]       new_page,
  output logic [BLOCK_W-1:0]      fill_block,
  output logic                    evicted,
  output logic [SLOT_W-1:0]       evicted_slot,
  output logic [PAGE_W-1:0]       evicted_page,
  output logic                    writeback,
  output logic [BLOCK_W-1:0]      writeback_block,
  output logic                    revoke_all
);

  // configuration and allocation state
  logic [FCNT_W-1:0]     frames_in_use;
  logic [BCNT_W-1:0]     blocks_in_use;
  logic [NUM_FRAMES-1:0] frame_taken;
  logic [NUM_FRAMES-1:0] frame_accessed;
  logic [NUM_BLOCKS-1:0] block_taken;
  logic [NUM_BLOCKS-1:0] block_on_disk;
  logic [PCNT_W-1:0]     pages_allocated [MAX_PROCS];
  logic [FRAME_W-1:0]    clock_hand;

  // memories
  pte_t              page_mem  [MAX_PROCS*MAX_PAGES];
  logic [KEY_W-1:0]  owner_mem [NUM_FRAMES];

  // working registers
  logic [SLOT_W-1:0]  slot;
  logic [PAGE_W-1:0]  page;
  logic [SCAN_W-1:0]  scan;
  logic [FRAME_W-1:0] victim;
  logic [BLOCK_W-1:0] key_block;
  logic [KEY_W-1:0]   owner;
  pte_t               pte;

  logic [1:0]         res_status, res_action;
  logic [FRAME_W-1:0] res_frame;
  logic [PAGE_W-1:0]  res_new_page, res_ev_page;
  logic [BLOCK_W-1:0] res_fill, res_wb_block;
  logic               res_evicted, res_wb, res_revoke;
  logic [SLOT_W-1:0]  res_ev_slot;

  logic [PCNT_W-1:0]  count;
  logic [FRAME_W-1:0] hand_next;
  logic               mem_we, mem_re;
  logic [KEY_W-1:0]   mem_waddr, mem_raddr;
  pte_t               mem_wdata;
  logic [FCNT_W-1:0]  cfg_frames;
  logic [BCNT_W-1:0]  cfg_blocks;

  assign count = pages_allocated[slot];
  assign hand_next = ((FCNT_W'(clock_hand) + FCNT_W'(1)) >= frames_in_use) ?
                     '0 : clock_hand + FRAME_W'(1);

  // conditions for the controller
  always_comb begin
    st.blk_end    = scan >= blocks_in_use;
    st.blk_hit    = !st.blk_end && !block_taken[scan[BLOCK_W-1:0]];
    st.tbl_full   = count >= PCNT_W'(MAX_PAGES);
    st.page_bad   = PCNT_W'(page) >= count;
    st.pte_res    = pte.resident;
    st.frm_end    = scan >= SCAN_W'(frames_in_use);
    st.frm_hit    = !st.frm_end && !frame_taken[scan[FRAME_W-1:0]];
    st.hand_clear = !frame_accessed[clock_hand];
    st.dst_more   = scan < SCAN_W'(count);
  end

  // clamped register values
  always_comb begin
    if (cfg_data[FCNT_W-1:0] == '0) cfg_frames = FCNT_W'(1);
    else if (cfg_data[FCNT_W-1:0] > FCNT_W'(NUM_FRAMES)) cfg_frames = FCNT_W'(NUM_FRAMES);
    else cfg_frames = cfg_data[FCNT_W-1:0];
    if (cfg_data == '0) cfg_blocks = BCNT_W'(1);
    else if (cfg_data > BCNT_W'(NUM_BLOCKS)) cfg_blocks = BCNT_W'(NUM_BLOCKS);
    else cfg_blocks = cfg_data;
  end

  // page table port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {slot, page};
    mem_raddr = {slot, page};
    mem_wdata = pte;
    case (op)
      OP_EXT_COMMIT: begin
        mem_we    = 1'b1;
        mem_waddr = {slot, count[PAGE_W-1:0]};
        mem_wdata = '{resident: 1'b0, dirty: 1'b0, frame: '0,
                      block: scan[BLOCK_W-1:0]};
      end
      OP_PTE_RD: mem_re = 1'b1;
      OP_GRANT: begin
        mem_we          = 1'b1;
        mem_wdata.dirty = 1'b1;
      end
      OP_VIC_RD: begin
        mem_re    = 1'b1;
        mem_raddr = owner;
      end
      OP_EVICT: begin
        mem_we             = 1'b1;
        mem_waddr          = owner;
        mem_wdata.resident = 1'b0;
        mem_wdata.dirty    = 1'b0;
      end
      OP_MAP: begin
        mem_we    = 1'b1;
        mem_wdata = '{resident: 1'b1, dirty: 1'b0, frame: victim, block: key_block};
      end
      OP_DST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {slot, scan[PAGE_W-1:0]};
      end
      OP_DST_FREE: begin
        mem_we             = 1'b1;
        mem_waddr          = {slot, scan[PAGE_W-1:0]};
        mem_wdata.resident = 1'b0;
        mem_wdata.dirty    = 1'b0;
      end
      default: ;
    endcase
  end

  // page table memory
  always_ff @(posedge clk) begin
    if (mem_we) page_mem[mem_waddr] <= mem_wdata;
    if (mem_re) pte <= page_mem[mem_raddr];
  end

  // frame owner memory
  always_ff @(posedge clk) begin
    if (op == OP_MAP) owner_mem[victim] <= {slot, page};
    if (op == OP_OWNER_RD) owner <= owner_mem[victim];
  end

  // allocation state, cleared by reset (sizes reset to the maximum)
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use  <= FCNT_W'(NUM_FRAMES);
      blocks_in_use  <= BCNT_W'(NUM_BLOCKS);
      frame_taken    <= '0;
      frame_accessed <= '0;
      block_taken    <= '0;
      block_on_disk  <= '0;
      clock_hand     <= '0;
      for (int i = 0; i < MAX_PROCS; i++) pages_allocated[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FRAMES) frames_in_use <= cfg_frames;
        else blocks_in_use <= cfg_blocks;
      end
      case (op)
        OP_EXT_COMMIT: begin
          pages_allocated[slot]           <= count + PCNT_W'(1);
          block_taken[scan[BLOCK_W-1:0]]  <= 1'b1;
        end
        OP_GRANT: frame_accessed[pte.frame] <= 1'b1;
        OP_HAND_NORM: begin
          if (FCNT_W'(clock_hand) >= frames_in_use) clock_hand <= '0;
        end
        OP_CLOCK_STEP: begin
          clock_hand <= hand_next;
          frame_accessed[clock_hand] <= 1'b0;
        end
        OP_EVICT: begin
          if (pte.dirty) block_on_disk[pte.block] <= 1'b1;
        end
        OP_MAP: begin
          frame_taken[victim]    <= 1'b1;
          frame_accessed[victim] <= 1'b1;
        end
        OP_DST_FREE: begin
          block_taken[pte.block]   <= 1'b0;
          block_on_disk[pte.block] <= 1'b0;
          if (pte.resident) frame_taken[pte.frame] <= 1'b0;
        end
        OP_DST_DONE: pages_allocated[slot] <= '0;
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (op)
      OP_START: begin
        slot         <= process_slot;
        page         <= page_index;
        scan         <= '0;
        res_status   <= ST_OK;
        res_action   <= ACT_NONE;
        res_frame    <= '0;
        res_new_page <= '0;
        res_fill     <= '0;
        res_evicted  <= 1'b0;
        res_ev_slot  <= '0;
        res_ev_page  <= '0;
        res_wb       <= 1'b0;
        res_wb_block <= '0;
        res_revoke   <= 1'b0;
      end
      OP_SCAN_INC: scan <= scan + SCAN_W'(1);
      OP_NO_BLOCK: res_status <= ST_NO_BLOCK;
      OP_EXT_FULL: res_status <= ST_TABLE_FULL;
      OP_BAD_PAGE: res_status <= ST_NOT_ALLOC;
      OP_EXT_COMMIT: begin
        res_new_page <= count[PAGE_W-1:0];
        res_fill     <= scan[BLOCK_W-1:0];
      end
      OP_GRANT: begin
        res_action <= ACT_GRANT_RW;
        res_frame  <= pte.frame;
      end
      OP_SAVE_BLK: begin
        key_block <= pte.block;
        scan      <= '0;
      end
      OP_TAKE_FREE: victim <= scan[FRAME_W-1:0];
      OP_CLOCK_STEP: victim <= clock_hand;
      OP_EVICT: begin
        res_evicted <= 1'b1;
        res_ev_slot <= owner[KEY_W-1:PAGE_W];
        res_ev_page <= owner[PAGE_W-1:0];
        res_wb      <= pte.dirty;
        res_wb_block <= pte.dirty ? pte.block : '0;
        res_revoke  <= (victim == '0);
      end
      OP_MAP: begin
        res_action <= block_on_disk[key_block] ? ACT_MAP_DISK : ACT_MAP_ZERO;
        res_frame  <= victim;
        res_fill   <= key_block;
      end
      OP_DST_FREE: scan <= scan + SCAN_W'(1);
      OP_LOAD: begin
        status          <= res_status;
        action          <= res_action;
        frame           <= res_frame;
        new_page        <= res_new_page;
        fill_block      <= res_fill;
        evicted         <= res_evicted;
        evicted_slot    <= res_ev_slot;
        evicted_page    <= res_ev_page;
        writeback       <= res_wb;
        writeback_block <= res_wb_block;
        revoke_all      <= res_revoke;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/clock_page_replacement_pager_top.sv
// extend: linear search for the lowest free block, one per cycle
// fault: a resident page gets a read-write grant; a miss maps a new frame
//   (free frame search, then the clock sweep if none is free, one frame per cycle)
// destroy: reads and frees each page of the slot in turn; one beat in flight at a time
// next beat is taken while the previous result still waits at the output
// reset: synchronous, clears allocation bits, page counts and clock hand, sets both sizes to the maximum
`default_nettype none
module clock_page_replacement_pager_top import cpr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         command,
  input  wire logic [SLOT_W-1:0]  process_slot,
  input  wire logic [PAGE_W-1:0]  page_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [1:0]              action,
  output logic [FRAME_W-1:0]      frame,
  output logic [PAGE_W-1:0]       new_page,
  output logic [BLOCK_W-1:0]      fill_block,
  output logic                    evicted,
  output logic [SLOT_W-1:0]       evicted_slot,
  output logic [PAGE_W-1:0]       evicted_page,
  output logic                    writeback,
  output logic [BLOCK_W-1:0]      writeback_block,
  output logic                    revoke_all,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [BCNT_W-1:0]  cfg_data
);

  op_t        op;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  // sequencer
  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .op        (op)
  );

  // tables and result registers
  cpr_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .process_slot    (process_slot),
    .page_index      (page_index),
    .st              (st),
    .status          (status),
    .action          (action),
    .frame           (frame),
    .new_page        (new_page),
    .fill_block      (fill_block),
    .evicted         (evicted),
    .evicted_slot    (evicted_slot),
    .evicted_page    (evicted_page),
    .writeback       (writeback),
    .writeback_block (writeback_block),
    .revoke_all      (revoke_all)
  );

  // busy after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // writeback only with an eviction
  a_wb_needs_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && writeback |-> evicted)
    else $error("writeback without eviction");

  // revoke only when frame 0 is the victim
  a_revoke_frame0: assert property (@(posedge clk) disable iff (rst)
    out_valid && revoke_all |-> evicted && frame == '0)
    else $error("revoke without frame 0 victim");

  // failed commands take no action
  a_fail_no_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> action == ACT_NONE)
    else $error("action on failed command");

endmodule
`default_nettype wire
